// ===== sv/rtc_with_timed_power_alarms_macros.svh =====
// Assertion macros for the real-time clock with timed power alarms.
// Included by the top level; relies on clk and rst_n in the including scope.
`ifndef RTC_WITH_TIMED_POWER_ALARMS_MACROS_SVH
`define RTC_WITH_TIMED_POWER_ALARMS_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define RTCPA_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rtcpa: invariant violated");

// Check that a condition implies a consequence in the following cycle.
`define RTCPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtcpa: sequence violated");

`endif

// ===== sv/rtcpa_pkg.sv =====
// Package for the real-time clock with timed power alarms.
// Holds request/response structs, operation codes and reset constants; no dependencies.
package rtcpa_pkg;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_SET_CLOCK = 2'd1,
        OP_SET_POWER = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        CFG_MODE_24_HOUR   = 3'd0,
        CFG_ALARM_ENABLES  = 3'd1,
        CFG_LEFT_ON_TIME   = 3'd2,
        CFG_LEFT_OFF_TIME  = 3'd3,
        CFG_RIGHT_ON_TIME  = 3'd4,
        CFG_RIGHT_OFF_TIME = 3'd5
    } cfg_index_t;

    // Bit positions inside alarm_enables
    localparam int unsigned EN_LEFT_ON   = 0;
    localparam int unsigned EN_LEFT_OFF  = 1;
    localparam int unsigned EN_RIGHT_ON  = 2;
    localparam int unsigned EN_RIGHT_OFF = 3;

    localparam int unsigned CFG_DATA_W = 12;

    localparam logic [5:0]  MAX_MIN_SEC    = 6'd59;
    localparam logic [4:0]  MAX_HOUR_12    = 5'd12;
    localparam logic [4:0]  MAX_HOUR_24    = 5'd23;
    localparam logic [4:0]  RESET_HOUR     = 5'd12;
    localparam logic [11:0] RESET_ON_TIME  = 12'd2669;
    localparam logic [11:0] RESET_OFF_TIME = 12'd414;

    typedef struct packed {
        logic [1:0] operation;
        logic [4:0] set_hours;
        logic [5:0] set_minutes;
        logic [5:0] set_seconds;
        logic       set_pm;
        logic       side;
        logic       power_value;
    } req_t;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       pm_flag;
        logic       left_power;
        logic       right_power;
        logic       left_changed;
        logic       right_changed;
    } rsp_t;

endpackage

// ===== sv/rtc_with_timed_power_alarms.sv =====
// Real-time clock with four timed power alarms: top level.
// Depends on rtcpa_pkg and rtc_with_timed_power_alarms_macros.svh.
//
// Usage:
//   A request (req_data, req_valid/req_ready) is a one-second tick, a clock
//   set or a manual power set for one side. Each request yields exactly one
//   response (rsp_data, rsp_valid/rsp_ready) with the time, both powers and
//   change flags. Alarms are evaluated only after a tick.
//   A request passes two register stages (request register, response register)
//   before its response is shown on rsp_data.
//   Throughput: one request per cycle; the clock update and the four alarm
//   compares sit in one short combinational step between the two registers.
//   When the receiver stalls, the response register holds and the request
//   register holds one more request; req_ready then drops.
//   Configuration: cfg_we writes register cfg_index from cfg_wdata at once;
//   write only while no request is in flight.
//   Reset (rst_n low, asynchronous): time 12:00:00 pm, 12-hour mode, both
//   powers off, alarms disabled, alarm times at their defaults, no request
//   or response pending.
`include "rtc_with_timed_power_alarms_macros.svh"

module rtc_with_timed_power_alarms (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  rtcpa_pkg::req_t                 req_data,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output rtcpa_pkg::rsp_t                 rsp_data,
    input  logic                            cfg_we,
    input  logic [2:0]                      cfg_index,
    input  logic [rtcpa_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers
    logic        mode_24_hour_reg;
    logic [3:0]  alarm_enables_reg;
    logic [11:0] left_on_time_reg;
    logic [11:0] left_off_time_reg;
    logic [11:0] right_on_time_reg;
    logic [11:0] right_off_time_reg;

    // Clock and power state
    logic [4:0] hour_reg,   hour_next;
    logic [5:0] minute_reg, minute_next;
    logic [5:0] second_reg, second_next;
    logic       pm_reg,     pm_next;
    logic       left_reg,   left_next;
    logic       right_reg,  right_next;

    // Pipeline registers
    logic             pend_reg;
    rtcpa_pkg::req_t  req_reg;
    logic             rsp_valid_reg;
    rtcpa_pkg::rsp_t  rsp_reg;

    logic advance;
    logic fire;

    // Tick arithmetic
    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [5:0] hour_inc;
    logic [4:0] tick_hour;
    logic [5:0] tick_min;
    logic [5:0] tick_sec;
    logic       tick_pm;

    // Clock set clamping
    logic [4:0] set_hour;
    logic [5:0] set_min;
    logic [5:0] set_sec;

    function automatic logic alarm_hit(
        input logic        en,
        input logic [11:0] when_time,
        input logic [4:0]  hr,
        input logic [5:0]  mn,
        input logic [5:0]  sc,
        input logic        pm,
        input logic        mode24
    );
        alarm_hit = en && (sc == 6'd0) && (when_time[5:0] == mn)
                    && (when_time[10:6] == hr) && (mode24 || (when_time[11] == pm));
    endfunction

    assign advance   = !rsp_valid_reg || rsp_ready;
    assign fire      = pend_reg && advance;
    assign req_ready = !pend_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_24_hour_reg   <= 1'b0;
            alarm_enables_reg  <= 4'd0;
            left_on_time_reg   <= rtcpa_pkg::RESET_ON_TIME;
            left_off_time_reg  <= rtcpa_pkg::RESET_OFF_TIME;
            right_on_time_reg  <= rtcpa_pkg::RESET_ON_TIME;
            right_off_time_reg <= rtcpa_pkg::RESET_OFF_TIME;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rtcpa_pkg::CFG_MODE_24_HOUR:   mode_24_hour_reg   <= cfg_wdata[0];
                rtcpa_pkg::CFG_ALARM_ENABLES:  alarm_enables_reg  <= cfg_wdata[3:0];
                rtcpa_pkg::CFG_LEFT_ON_TIME:   left_on_time_reg   <= cfg_wdata[11:0];
                rtcpa_pkg::CFG_LEFT_OFF_TIME:  left_off_time_reg  <= cfg_wdata[11:0];
                rtcpa_pkg::CFG_RIGHT_ON_TIME:  right_on_time_reg  <= cfg_wdata[11:0];
                rtcpa_pkg::CFG_RIGHT_OFF_TIME: right_off_time_reg <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // Advance one second with minute and hour rollover
    always_comb
    begin
        sec_inc   = {1'b0, second_reg} + 7'd1;
        min_inc   = {1'b0, minute_reg} + 7'd1;
        hour_inc  = {1'b0, hour_reg} + 6'd1;
        tick_sec  = sec_inc[5:0];
        tick_min  = minute_reg;
        tick_hour = hour_reg;
        tick_pm   = pm_reg;
        if (sec_inc > {1'b0, rtcpa_pkg::MAX_MIN_SEC})
        begin
            tick_sec = 6'd0;
            tick_min = min_inc[5:0];
            if (min_inc > {1'b0, rtcpa_pkg::MAX_MIN_SEC})
            begin
                tick_min = 6'd0;
                if (mode_24_hour_reg)
                begin
                    tick_hour = (hour_inc > {1'b0, rtcpa_pkg::MAX_HOUR_24}) ?
                                5'd0 : hour_inc[4:0];
                end
                else
                begin
                    tick_hour = (hour_inc > {1'b0, rtcpa_pkg::MAX_HOUR_12}) ?
                                5'd1 : hour_inc[4:0];
                    // Hour reaching twelve flips am/pm
                    if (tick_hour == rtcpa_pkg::MAX_HOUR_12)
                        tick_pm = !pm_reg;
                end
            end
        end
    end

    // Clamp a clock set to the limits of the current mode
    always_comb
    begin
        set_hour = req_reg.set_hours;
        if (mode_24_hour_reg)
        begin
            if (set_hour > rtcpa_pkg::MAX_HOUR_24)
                set_hour = rtcpa_pkg::MAX_HOUR_24;
        end
        else
        begin
            if (set_hour > rtcpa_pkg::MAX_HOUR_12)
                set_hour = rtcpa_pkg::MAX_HOUR_12;
            if (set_hour == 5'd0)
                set_hour = 5'd1;
        end
        set_min = (req_reg.set_minutes > rtcpa_pkg::MAX_MIN_SEC) ?
                  rtcpa_pkg::MAX_MIN_SEC : req_reg.set_minutes;
        set_sec = (req_reg.set_seconds > rtcpa_pkg::MAX_MIN_SEC) ?
                  rtcpa_pkg::MAX_MIN_SEC : req_reg.set_seconds;
    end

    // Next state for the request held in the request register
    always_comb
    begin
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        pm_next     = pm_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        if (fire)
        begin
            case (req_reg.operation)
                rtcpa_pkg::OP_TICK:
                begin
                    hour_next   = tick_hour;
                    minute_next = tick_min;
                    second_next = tick_sec;
                    pm_next     = tick_pm;
                    // Off alarms are checked last so they win
                    if (alarm_hit(alarm_enables_reg[rtcpa_pkg::EN_LEFT_ON], left_on_time_reg,
                                  tick_hour, tick_min, tick_sec, tick_pm, mode_24_hour_reg))
                        left_next = 1'b1;
                    if (alarm_hit(alarm_enables_reg[rtcpa_pkg::EN_RIGHT_ON], right_on_time_reg,
                                  tick_hour, tick_min, tick_sec, tick_pm, mode_24_hour_reg))
                        right_next = 1'b1;
                    if (alarm_hit(alarm_enables_reg[rtcpa_pkg::EN_LEFT_OFF], left_off_time_reg,
                                  tick_hour, tick_min, tick_sec, tick_pm, mode_24_hour_reg))
                        left_next = 1'b0;
                    if (alarm_hit(alarm_enables_reg[rtcpa_pkg::EN_RIGHT_OFF], right_off_time_reg,
                                  tick_hour, tick_min, tick_sec, tick_pm, mode_24_hour_reg))
                        right_next = 1'b0;
                end
                rtcpa_pkg::OP_SET_CLOCK:
                begin
                    hour_next   = set_hour;
                    minute_next = set_min;
                    second_next = set_sec;
                    pm_next     = req_reg.set_pm;
                end
                rtcpa_pkg::OP_SET_POWER:
                begin
                    if (req_reg.side)
                        right_next = req_reg.power_value;
                    else
                        left_next = req_reg.power_value;
                end
                default: ;
            endcase
        end
    end

    // Clock and power state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_reg   <= rtcpa_pkg::RESET_HOUR;
            minute_reg <= 6'd0;
            second_reg <= 6'd0;
            pm_reg     <= 1'b1;
            left_reg   <= 1'b0;
            right_reg  <= 1'b0;
        end
        else
        begin
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            pm_reg     <= pm_next;
            left_reg   <= left_next;
            right_reg  <= right_next;
        end
    end

    // Handshake control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
                pend_reg <= req_valid;
            if (advance)
                rsp_valid_reg <= pend_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            req_reg <= req_data;
        if (fire)
        begin
            rsp_reg.hours         <= hour_next;
            rsp_reg.minutes       <= minute_next;
            rsp_reg.seconds       <= second_next;
            rsp_reg.pm_flag       <= pm_next;
            rsp_reg.left_power    <= left_next;
            rsp_reg.right_power   <= right_next;
            rsp_reg.left_changed  <= left_next != left_reg;
            rsp_reg.right_changed <= right_next != right_reg;
        end
    end

    `RTCPA_ASSERT_ALWAYS(a_time_in_range,
        (second_reg <= rtcpa_pkg::MAX_MIN_SEC) && (minute_reg <= rtcpa_pkg::MAX_MIN_SEC))
    `RTCPA_ASSERT_NEXT(a_pend_held_on_stall, pend_reg && !advance, pend_reg)
    `RTCPA_ASSERT_NEXT(a_tick_counts_second,
        fire && (req_reg.operation == rtcpa_pkg::OP_TICK) && (second_reg < 6'd59),
        second_reg == $past(second_reg) + 6'd1)

endmodule
